/* rtl/core/dual_uart_fifo_registers_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the dual UART register block
// Shared property templates used by the block's checker.
// ---------------------------------------------------------------------------
`ifndef DUAL_UART_FIFO_REGISTERS_MACROS_SVH
`define DUAL_UART_FIFO_REGISTERS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define DUF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DUF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/duf_pkg.sv */
// ---------------------------------------------------------------------------
// duf_pkg
// Types, codes, sizes and helper functions of the dual UART register block.
// ---------------------------------------------------------------------------
package duf_pkg;

    // FIFO sizes
    localparam int RX_DEPTH = 16;
    localparam int TX_DEPTH = 16;
    localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
    localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LVL0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LVL1 = CFG_IDX_W'(1);

    // Request kinds
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_LINE  = 2'd2;
    localparam logic [1:0] REQ_POLL  = 2'd3;

    // Register offsets within one channel
    localparam logic [1:0] OFF_TX      = 2'd0;
    localparam logic [1:0] OFF_RX      = 2'd1;
    localparam logic [1:0] OFF_STATUS  = 2'd2;
    localparam logic [1:0] OFF_CONTROL = 2'd3;
    localparam logic [3:0] MAP_SIZE    = 4'd8;

    // Status bits
    localparam int ST_RX_READY = 0;
    localparam int ST_TX_EMPTY = 1;
    localparam int ST_OVERRUN  = 2;
    localparam int ST_FRAME    = 3;
    localparam int ST_BREAK    = 4;
    localparam logic [4:0] ST_ERR_MASK = 5'b11100;
    localparam logic [4:0] ST_RESET    = 5'b00010;

    // Control bits
    localparam int CT_TX_EN     = 0;
    localparam int CT_RX_EN     = 1;
    localparam int CT_TX_INT    = 2;
    localparam int CT_RX_INT    = 3;
    localparam int CT_LOOPBACK  = 4;
    localparam int CT_RESET_ERR = 5;

    // Interrupt level reset values
    localparam logic [2:0] LVL0_RESET = 3'd4;
    localparam logic [2:0] LVL1_RESET = 3'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the accepted item
        logic exec;      // apply one step to the selected channel
        logic poll_ch;   // channel served by a poll step
        logic load_out;  // write the result register
    } duf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_poll;
    } duf_stat_t;

    // Channel asks for service
    function automatic logic chan_active(input logic [4:0] st, input logic [5:0] ctl);
        chan_active = (st[ST_TX_EMPTY] & ctl[CT_TX_INT]) | (st[ST_RX_READY] & ctl[CT_RX_INT]);
    endfunction

    // Priority rule: take own level, drop to zero, or hold for the other channel
    function automatic logic [2:0] irq_update(input logic [2:0] cur, input logic self_act,
                                              input logic other_act, input logic [2:0] level);
        if (self_act)
        begin
            irq_update = level;
        end
        else if (!other_act)
        begin
            irq_update = 3'd0;
        end
        else
        begin
            irq_update = cur;
        end
    endfunction

endpackage

/* rtl/core/duf_ctrl.sv */
// ---------------------------------------------------------------------------
// duf_ctrl
// Sequencer: accepts an item, runs its steps and hands off the result.
// ---------------------------------------------------------------------------
module duf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output duf_pkg::duf_cmd_t  cmd,
    input  duf_pkg::duf_stat_t stat
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_POLL1 = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // Result register can take a new value
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.is_poll)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_POLL1;
                end
                else if (out_free)
                begin
                    cmd.exec     = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_POLL1:
            begin
                if (out_free)
                begin
                    cmd.exec     = 1'b1;
                    cmd.poll_ch  = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the transfer completes
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/duf_datapath.sv */
// ---------------------------------------------------------------------------
// duf_datapath
// Register map, FIFOs and interrupt level of both channels.
// ---------------------------------------------------------------------------
module duf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  duf_pkg::duf_cmd_t                   cmd,
    output duf_pkg::duf_stat_t                  stat,
    input  logic [1:0]                          req_type,
    input  logic [3:0]                          address,
    input  logic [7:0]                          write_data,
    input  logic                                channel,
    input  logic [7:0]                          rx_byte,
    input  logic                                cfg_we,
    input  logic [duf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [duf_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [duf_pkg::M_TDATA_W-1:0]       out_tdata,
    output logic [duf_pkg::M_TUSER_W-1:0]       out_tuser
);

    // Captured item
    logic [1:0] req_type_reg;
    logic [3:0] address_reg;
    logic [7:0] write_data_reg;
    logic       channel_reg;
    logic [7:0] rx_byte_reg;

    // Per-channel state
    logic [2:0] lvl_reg      [2];
    logic [5:0] ctl_reg      [2];
    logic [4:0] st_reg       [2];
    logic [7:0] rx_hold_reg  [2];
    logic [duf_pkg::RX_PTR_W-1:0] rx_head_reg  [2];
    logic [duf_pkg::RX_CNT_W-1:0] rx_count_reg [2];
    logic [duf_pkg::TX_PTR_W-1:0] tx_head_reg  [2];
    logic [duf_pkg::TX_CNT_W-1:0] tx_count_reg [2];
    logic [7:0] rx_mem_reg [2][duf_pkg::RX_DEPTH];
    logic [7:0] tx_mem_reg [2][duf_pkg::TX_DEPTH];
    logic [2:0] irq_reg;
    logic [2:0] irq_next;

    // Channel 0 poll result kept until the result register is written
    logic       keep_v_reg;
    logic [7:0] keep_b_reg;

    logic [duf_pkg::M_TDATA_W-1:0] out_tdata_reg;
    logic [duf_pkg::M_TUSER_W-1:0] out_tuser_reg;

    // Selected channel view
    logic       is_poll;
    logic       sel;
    logic       in_map;
    logic       other_act;
    logic [5:0] ctl;
    logic [4:0] st;
    logic [duf_pkg::RX_PTR_W-1:0] rxh;
    logic [duf_pkg::RX_CNT_W-1:0] rxc;
    logic [duf_pkg::TX_PTR_W-1:0] txh;
    logic [duf_pkg::TX_CNT_W-1:0] txc;
    logic [7:0] rx_head_data;
    logic [7:0] tx_head_data;
    logic [duf_pkg::RX_CNT_W:0]   rx_sum;
    logic [duf_pkg::TX_CNT_W:0]   tx_sum;
    logic [duf_pkg::RX_PTR_W-1:0] rx_tail;
    logic [duf_pkg::TX_PTR_W-1:0] tx_tail;
    logic [duf_pkg::RX_PTR_W-1:0] rx_head_inc;
    logic [duf_pkg::TX_PTR_W-1:0] tx_head_inc;

    // Step results
    logic [5:0] ctl_next;
    logic [4:0] st_next;
    logic [7:0] hold_next;
    logic [duf_pkg::RX_PTR_W-1:0] rxh_next;
    logic [duf_pkg::RX_CNT_W-1:0] rxc_next;
    logic [duf_pkg::TX_PTR_W-1:0] txh_next;
    logic [duf_pkg::TX_CNT_W-1:0] txc_next;
    logic       rx_we;
    logic [7:0] rx_wdata;
    logic       tx_we;
    logic       do_line;
    logic [7:0] line_b;
    logic [7:0] rd;
    logic       step_txv;
    logic [7:0] step_txb;
    logic       tx1_v;
    logic [7:0] tx1_b;

    assign is_poll      = (req_type_reg == duf_pkg::REQ_POLL);
    assign stat.is_poll = is_poll;

    // Pick the channel the step works on
    always_comb
    begin
        if (is_poll)
        begin
            sel = cmd.poll_ch;
        end
        else if (req_type_reg == duf_pkg::REQ_LINE)
        begin
            sel = channel_reg;
        end
        else
        begin
            sel = address_reg[2];
        end
    end

    assign in_map       = (address_reg < duf_pkg::MAP_SIZE);
    assign ctl          = ctl_reg[sel];
    assign st           = st_reg[sel];
    assign rxh          = rx_head_reg[sel];
    assign rxc          = rx_count_reg[sel];
    assign txh          = tx_head_reg[sel];
    assign txc          = tx_count_reg[sel];
    assign other_act    = duf_pkg::chan_active(st_reg[~sel], ctl_reg[~sel]);
    assign rx_head_data = rx_mem_reg[sel][rxh];
    assign tx_head_data = tx_mem_reg[sel][txh];

    // FIFO tail and head advance with wrap
    assign rx_sum  = (duf_pkg::RX_CNT_W+1)'(rxh) + (duf_pkg::RX_CNT_W+1)'(rxc);
    assign tx_sum  = (duf_pkg::TX_CNT_W+1)'(txh) + (duf_pkg::TX_CNT_W+1)'(txc);
    assign rx_tail = (rx_sum >= (duf_pkg::RX_CNT_W+1)'(duf_pkg::RX_DEPTH))
                   ? duf_pkg::RX_PTR_W'(rx_sum - (duf_pkg::RX_CNT_W+1)'(duf_pkg::RX_DEPTH))
                   : duf_pkg::RX_PTR_W'(rx_sum);
    assign tx_tail = (tx_sum >= (duf_pkg::TX_CNT_W+1)'(duf_pkg::TX_DEPTH))
                   ? duf_pkg::TX_PTR_W'(tx_sum - (duf_pkg::TX_CNT_W+1)'(duf_pkg::TX_DEPTH))
                   : duf_pkg::TX_PTR_W'(tx_sum);
    assign rx_head_inc = (rxh == duf_pkg::RX_PTR_W'(duf_pkg::RX_DEPTH - 1)) ? '0 : rxh + 1'b1;
    assign tx_head_inc = (txh == duf_pkg::TX_PTR_W'(duf_pkg::TX_DEPTH - 1)) ? '0 : txh + 1'b1;

    // One step on the selected channel: request, then loopback byte, then poll empty check
    always_comb
    begin
        ctl_next  = ctl;
        st_next   = st;
        hold_next = rx_hold_reg[sel];
        rxh_next  = rxh;
        rxc_next  = rxc;
        txh_next  = txh;
        txc_next  = txc;
        irq_next  = irq_reg;
        rx_we     = 1'b0;
        rx_wdata  = rx_byte_reg;
        tx_we     = 1'b0;
        do_line   = 1'b0;
        line_b    = rx_byte_reg;
        rd        = 8'd0;
        step_txv  = 1'b0;
        step_txb  = 8'd0;

        case (req_type_reg)
            duf_pkg::REQ_READ:
            begin
                if (in_map)
                begin
                    case (address_reg[1:0])
                        duf_pkg::OFF_RX:
                        begin
                            if (rxc != '0)
                            begin
                                hold_next = rx_head_data;
                                rxh_next  = rx_head_inc;
                                rxc_next  = rxc - 1'b1;
                                if (rxc == duf_pkg::RX_CNT_W'(1))
                                begin
                                    st_next[duf_pkg::ST_RX_READY] = 1'b0;
                                    irq_next = duf_pkg::irq_update(irq_reg,
                                        duf_pkg::chan_active(st_next, ctl), other_act,
                                        lvl_reg[sel]);
                                end
                            end
                            rd = hold_next;
                        end
                        duf_pkg::OFF_STATUS:
                        begin
                            rd = {3'b000, st};
                        end
                        duf_pkg::OFF_CONTROL:
                        begin
                            rd = {2'b00, ctl};
                        end
                        default:
                        begin
                            rd = 8'd0;
                        end
                    endcase
                end
            end
            duf_pkg::REQ_WRITE:
            begin
                if (in_map)
                begin
                    case (address_reg[1:0])
                        duf_pkg::OFF_TX:
                        begin
                            if (ctl[duf_pkg::CT_TX_EN] &&
                                (txc < duf_pkg::TX_CNT_W'(duf_pkg::TX_DEPTH)))
                            begin
                                tx_we    = 1'b1;
                                txc_next = txc + 1'b1;
                                st_next[duf_pkg::ST_TX_EMPTY] = 1'b0;
                                irq_next = duf_pkg::irq_update(irq_reg,
                                    duf_pkg::chan_active(st_next, ctl), other_act,
                                    lvl_reg[sel]);
                            end
                        end
                        duf_pkg::OFF_STATUS:
                        begin
                            st_next = st & ~(write_data_reg[4:0] & duf_pkg::ST_ERR_MASK);
                        end
                        duf_pkg::OFF_CONTROL:
                        begin
                            ctl_next = write_data_reg[5:0];
                            if (!ctl[duf_pkg::CT_TX_EN] && write_data_reg[duf_pkg::CT_TX_EN])
                            begin
                                st_next[duf_pkg::ST_TX_EMPTY] = 1'b1;
                            end
                            if (write_data_reg[duf_pkg::CT_RESET_ERR])
                            begin
                                st_next = st_next & ~duf_pkg::ST_ERR_MASK;
                            end
                            irq_next = duf_pkg::irq_update(irq_reg,
                                duf_pkg::chan_active(st_next, ctl_next), other_act,
                                lvl_reg[sel]);
                        end
                        default:
                        begin
                            st_next = st;
                        end
                    endcase
                end
            end
            duf_pkg::REQ_LINE:
            begin
                do_line = 1'b1;
            end
            default:
            begin
                if (ctl[duf_pkg::CT_TX_EN] && (txc != '0))
                begin
                    step_txv = 1'b1;
                    step_txb = tx_head_data;
                    txh_next = tx_head_inc;
                    txc_next = txc - 1'b1;
                    line_b   = tx_head_data;
                    do_line  = ctl[duf_pkg::CT_LOOPBACK];
                end
            end
        endcase

        // Queue a line or loopback byte, or flag overrun
        if (do_line && ctl[duf_pkg::CT_RX_EN])
        begin
            if (rxc < duf_pkg::RX_CNT_W'(duf_pkg::RX_DEPTH))
            begin
                rx_we    = 1'b1;
                rx_wdata = line_b;
                rxc_next = rxc + 1'b1;
                st_next[duf_pkg::ST_RX_READY] = 1'b1;
                irq_next = duf_pkg::irq_update(irq_next,
                    duf_pkg::chan_active(st_next, ctl), other_act, lvl_reg[sel]);
            end
            else
            begin
                st_next[duf_pkg::ST_OVERRUN] = 1'b1;
            end
        end

        // Poll finding the transmit FIFO empty
        if (is_poll && ctl[duf_pkg::CT_TX_EN] && (txc_next == '0))
        begin
            st_next[duf_pkg::ST_TX_EMPTY] = 1'b1;
            irq_next = duf_pkg::irq_update(irq_next,
                duf_pkg::chan_active(st_next, ctl), other_act, lvl_reg[sel]);
        end
    end

    // Channel 1 byte only shows on the final poll step
    assign tx1_v = is_poll & step_txv;
    assign tx1_b = is_poll ? step_txb : 8'd0;

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg   <= req_type;
            address_reg    <= address;
            write_data_reg <= write_data;
            channel_reg    <= channel;
            rx_byte_reg    <= rx_byte;
        end
    end

    // FIFO storage
    always_ff @(posedge clk)
    begin
        if (cmd.exec && rx_we)
        begin
            rx_mem_reg[sel][rx_tail] <= rx_wdata;
        end
        if (cmd.exec && tx_we)
        begin
            tx_mem_reg[sel][tx_tail] <= write_data_reg;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_tdata_reg <= {5'b00000, irq_next, tx1_b, keep_b_reg, rd};
            out_tuser_reg <= {tx1_v, keep_v_reg};
        end
    end

    // Channel state, interrupt level and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                ctl_reg[i]      <= '0;
                st_reg[i]       <= duf_pkg::ST_RESET;
                rx_hold_reg[i]  <= '0;
                rx_head_reg[i]  <= '0;
                rx_count_reg[i] <= '0;
                tx_head_reg[i]  <= '0;
                tx_count_reg[i] <= '0;
            end
            lvl_reg[0] <= duf_pkg::LVL0_RESET;
            lvl_reg[1] <= duf_pkg::LVL1_RESET;
            irq_reg    <= '0;
            keep_v_reg <= 1'b0;
            keep_b_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                lvl_reg[cfg_index] <= cfg_data;
            end
            if (cmd.load)
            begin
                keep_v_reg <= 1'b0;
                keep_b_reg <= '0;
            end
            if (cmd.exec)
            begin
                ctl_reg[sel]      <= ctl_next;
                st_reg[sel]       <= st_next;
                rx_hold_reg[sel]  <= hold_next;
                rx_head_reg[sel]  <= rxh_next;
                rx_count_reg[sel] <= rxc_next;
                tx_head_reg[sel]  <= txh_next;
                tx_count_reg[sel] <= txc_next;
                irq_reg           <= irq_next;
                if (is_poll && !cmd.poll_ch)
                begin
                    keep_v_reg <= step_txv;
                    keep_b_reg <= step_txb;
                end
            end
        end
    end

    assign out_tdata = out_tdata_reg;
    assign out_tuser = out_tuser_reg;

endmodule

/* rtl/core/dual_uart_fifo_registers.sv */
// ---------------------------------------------------------------------------
// dual_uart_fifo_registers
// Each item is captured in IDLE and executed in EXEC; a poll tick adds a second step (POLL1)
// for channel 1. The result register is written in the last step. A new item is accepted only
// in IDLE, after the previous result is written, so a stalled result holds input off.
// Reset: asynchronous; FIFOs empty, both channels disabled, no storage sweep.
// ---------------------------------------------------------------------------
module dual_uart_fifo_registers (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // address[3:0], write_data[11:4], rx_byte[19:12], zero[23:20]
    input  logic [duf_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // req_type[1:0], channel[2]
    input  logic [duf_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_data[7:0], tx0_byte[15:8], tx1_byte[23:16], irq_level[26:24], zero[31:27]
    output logic [duf_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // tx0_valid[0], tx1_valid[1]
    output logic [duf_pkg::M_TUSER_W-1:0]     m_axis_tuser,
    input  logic                              cfg_we,
    input  logic [duf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [duf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    duf_pkg::duf_cmd_t  cmd;
    duf_pkg::duf_stat_t stat;

    // Sequencer
    duf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Register map and FIFOs
    duf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (s_axis_tuser[1:0]),
        .address    (s_axis_tdata[3:0]),
        .write_data (s_axis_tdata[11:4]),
        .channel    (s_axis_tuser[2]),
        .rx_byte    (s_axis_tdata[19:12]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_tdata  (m_axis_tdata),
        .out_tuser  (m_axis_tuser)
    );

endmodule

/* rtl/core/duf_checker.sv */
// ---------------------------------------------------------------------------
// duf_checker
// Port-level checks of the dual UART register block, bound to the top level.
// ---------------------------------------------------------------------------
`include "dual_uart_fifo_registers_macros.svh"

module duf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [duf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [duf_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    // An idle transmitter reports a zero byte
    `DUF_ASSERT_SAME(a_tx0_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[15:8] == 8'd0, "tx0 byte not zero without tx0_valid")
    `DUF_ASSERT_SAME(a_tx1_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata[23:16] == 8'd0, "tx1 byte not zero without tx1_valid")

    // One item at a time: input closes after each transfer
    `DUF_ASSERT_NEXT(a_one_item, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input still ready after a transfer")

    // A stalled result holds
    `DUF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind dual_uart_fifo_registers duf_checker u_duf_checker (.*);
